### src/tpd_pkg.sv
// Shared types and constants of the ternary packed dot product block.
package tpd_pkg;

  typedef struct packed {
    logic              op;
    logic signed [7:0] activation;
    logic [7:0]        weight_byte;
  } item_t;

  typedef struct packed {
    logic [31:0]        result_bits;
    logic signed [31:0] dot;
    logic [15:0]        row_index;
  } result_t;

  localparam logic [1:0] REG_VECTOR_LENGTH    = 2'd0;
  localparam logic [1:0] REG_ACTIVATION_SCALE = 2'd1;
  localparam logic [1:0] REG_WEIGHT_SCALE     = 2'd2;

  localparam logic OP_ACTIVATION = 1'b0;
  localparam logic OP_WEIGHT     = 1'b1;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  // controller to datapath
  typedef struct packed {
    logic act_wr;
    logic wgt_rd;
    logic mac;
    logic cnv_step;
    logic fmul_start;
    logic sel_final;
    logic scale_ld;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_end;
    logic cnv_norm;
    logic fmul_done;
  } status_t;

endpackage

### src/tpd_ram.sv
// Generic single-port-write RAM with registered read.
module tpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tpd_fmul.sv
// Iterative fp32 multiplier, round to nearest even, subnormals supported.
module tpd_fmul
  import tpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] result,
  output logic        done
);

  typedef enum logic [4:0] {
    F_IDLE   = 5'b00001,
    F_MUL    = 5'b00010,
    F_NORM   = 5'b00100,
    F_DENORM = 5'b01000,
    F_ROUND  = 5'b10000
  } fstate_t;

  fstate_t state;
  logic [23:0] ma, mb;
  logic [47:0] prod;
  logic signed [10:0] expo;
  logic sign, sticky;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] a_m, b_m;
  logic [10:0] a_e, b_e;
  logic [24:0] mr;
  logic rnd_up;
  logic signed [10:0] expo_r;
  logic [31:0] rnd_bits;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    a_m = {a[30:23] != 8'h00, a[22:0]};
    b_m = {b[30:23] != 8'h00, b[22:0]};
    a_e = (a[30:23] == 8'h00) ? 11'd1 : {3'b000, a[30:23]};
    b_e = (b[30:23] == 8'h00) ? 11'd1 : {3'b000, b[30:23]};
  end

  always_comb begin
    rnd_up = prod[23] && ((|prod[22:0]) || sticky || prod[24]);
    mr = {1'b0, prod[47:24]} + {24'd0, rnd_up};
    expo_r = mr[24] ? expo + 11'sd1 : expo;
    if (expo_r >= 11'sd255) begin
      rnd_bits = {sign, 8'hFF, 23'd0};
    end else if (mr[24]) begin
      rnd_bits = {sign, expo_r[7:0], 23'd0};
    end else begin
      rnd_bits = {sign, mr[23] ? expo[7:0] : 8'h00, mr[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (start) begin
            sign <= a[31] ^ b[31];
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
              result <= FP_QNAN;
              done   <= 1'b1;
            end else if (a_inf || b_inf) begin
              result <= {a[31] ^ b[31], 8'hFF, 23'd0};
              done   <= 1'b1;
            end else if (a_zero || b_zero) begin
              result <= {a[31] ^ b[31], 31'd0};
              done   <= 1'b1;
            end else begin
              ma     <= a_m;
              mb     <= b_m;
              expo   <= $signed(a_e + b_e - 11'd126);
              sticky <= 1'b0;
              state  <= F_MUL;
            end
          end
        end
        F_MUL: begin
          prod  <= ma * mb;
          state <= F_NORM;
        end
        F_NORM: begin
          if (!prod[47] && (expo > 11'sd1)) begin
            prod <= {prod[46:0], 1'b0};
            expo <= expo - 11'sd1;
          end else begin
            state <= F_DENORM;
          end
        end
        F_DENORM: begin
          // shift into the subnormal range, collecting lost bits
          if (expo < 11'sd1) begin
            sticky <= sticky | prod[0];
            prod   <= {1'b0, prod[47:1]};
            expo   <= expo + 11'sd1;
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          result <= rnd_bits;
          done   <= 1'b1;
          state  <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### src/tpd_datapath.sv
// Datapath: config registers, activation store, accumulator, int to fp32, scaling.
module tpd_datapath
  import tpd_pkg::*;
#(
  parameter int MAX_VECTOR = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  item_t       item,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        done,
  output result_t     result
);

  localparam int LW    = $clog2(MAX_VECTOR + 1);
  localparam int DEPTH = MAX_VECTOR / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(DEPTH + 1);
  localparam int CW    = (LW > 13) ? LW : 13;

  logic [12:0]    vector_length;
  logic [31:0]    activation_scale, weight_scale;
  logic [LW-1:0]  load_position;
  logic [31:0]    activation_sum, row_accumulator;
  logic [BW-1:0]  byte_position, rd_pos;
  logic [7:0]     wbyte;
  logic [15:0]    row_counter;
  logic [31:0]    cm, scale;
  logic           cs;
  logic [4:0]     csh;

  logic [CW-1:0]  vl_x;
  logic [LW-1:0]  eff_len, pos_w;
  logic [BW-1:0]  nbytes, pos_r;
  logic [7:0]     ram_q [4];
  logic signed [12:0] psum;
  logic [31:0]    acc_new, dot_new;
  logic [31:0]    dotf;
  logic [7:0]     cexp;
  logic [24:0]    cmr;
  logic           cup;
  logic [31:0]    fa, fb, fres;
  logic           fdone;

  always_comb begin
    vl_x = CW'(vector_length);
    if (vl_x < CW'(4)) begin
      eff_len = LW'(4);
    end else if (vl_x > CW'(MAX_VECTOR)) begin
      eff_len = LW'(MAX_VECTOR);
    end else begin
      eff_len = LW'(vl_x);
    end
    nbytes = BW'(eff_len >> 2);
    pos_w  = (load_position >= eff_len) ? '0 : load_position;
    pos_r  = (byte_position >= nbytes) ? '0 : byte_position;
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    tpd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (cmd.act_wr && (pos_w[1:0] == 2'(i))),
      .waddr (pos_w[AW+1:2]),
      .wdata (item.activation),
      .raddr (pos_r[AW-1:0]),
      .rdata (ram_q[i])
    );
  end

  always_comb begin
    psum = '0;
    for (int i = 0; i < 4; i++) begin
      psum = psum + (13'($signed({1'b0, wbyte[2*i +: 2]})) * 13'($signed(ram_q[i])));
    end
    acc_new = row_accumulator + {{19{psum[12]}}, psum};
    dot_new = acc_new - activation_sum;
    status.row_end  = ({1'b0, rd_pos} + (BW+1)'(1)) >= {1'b0, nbytes};
    status.cnv_norm = cm[31] || (cm == '0);
    status.fmul_done = fdone;
  end

  // rounding of the normalized magnitude to fp32
  always_comb begin
    cup  = cm[7] && ((|cm[6:0]) || cm[8]);
    cmr  = {1'b0, cm[31:8]} + {24'd0, cup};
    cexp = 8'd158 - {3'b000, csh} + {7'd0, cmr[24]};
    if (cm == '0) begin
      dotf = '0;
    end else begin
      dotf = {cs, cexp, cmr[22:0]};
    end
    fa = cmd.sel_final ? dotf : activation_scale;
    fb = cmd.sel_final ? scale : weight_scale;
  end

  tpd_fmul u_fmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.fmul_start),
    .a      (fa),
    .b      (fb),
    .result (fres),
    .done   (fdone)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length    <= 13'd4096;
      activation_scale <= FP_ONE;
      weight_scale     <= FP_ONE;
      load_position    <= '0;
      activation_sum   <= '0;
      row_accumulator  <= '0;
      byte_position    <= '0;
      row_counter      <= '0;
      done             <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (wr_en) begin
        unique case (wr_index)
          REG_VECTOR_LENGTH:    vector_length    <= wr_data[12:0];
          REG_ACTIVATION_SCALE: activation_scale <= wr_data;
          REG_WEIGHT_SCALE:     weight_scale     <= wr_data;
          default: ;
        endcase
      end
      if (cmd.act_wr) begin
        activation_sum  <= ((load_position >= eff_len) ? 32'd0 : activation_sum)
                           + {{24{item.activation[7]}}, item.activation};
        load_position   <= pos_w + LW'(1);
        row_accumulator <= '0;
        byte_position   <= '0;
        row_counter     <= '0;
      end
      if (cmd.mac) begin
        if (status.row_end) begin
          row_accumulator <= '0;
          byte_position   <= '0;
        end else begin
          row_accumulator <= acc_new;
          byte_position   <= rd_pos + BW'(1);
        end
      end
      if (cmd.emit) begin
        row_counter <= row_counter + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt_rd) begin
      rd_pos <= pos_r;
      wbyte  <= item.weight_byte;
    end
    if (cmd.mac && status.row_end) begin
      result.dot <= dot_new;
      cs  <= dot_new[31];
      cm  <= dot_new[31] ? (32'd0 - dot_new) : dot_new;
      csh <= '0;
    end
    if (cmd.cnv_step && !status.cnv_norm) begin
      cm  <= {cm[30:0], 1'b0};
      csh <= csh + 5'd1;
    end
    if (cmd.scale_ld) begin
      scale <= fres;
    end
    if (cmd.emit) begin
      result.result_bits <= fres;
      result.row_index   <= row_counter;
    end
  end

endmodule

### src/tpd_ctrl.sv
// Controller state machine sequencing loads, MACs and the end-of-row scaling.
module tpd_ctrl
  import tpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    op,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAC    = 7'b0000010,
    S_CNV    = 7'b0000100,
    S_MULS   = 7'b0001000,
    S_WAITS  = 7'b0010000,
    S_MULR   = 7'b0100000,
    S_WAITR  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_ACTIVATION) begin
            cmd.act_wr = 1'b1;
          end else begin
            cmd.wgt_rd = 1'b1;
            state_next = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        state_next = status.row_end ? S_CNV : S_IDLE;
      end
      S_CNV: begin
        cmd.cnv_step = 1'b1;
        if (status.cnv_norm) state_next = S_MULS;
      end
      S_MULS: begin
        cmd.fmul_start = 1'b1;
        state_next = S_WAITS;
      end
      S_WAITS: begin
        if (status.fmul_done) begin
          cmd.scale_ld = 1'b1;
          state_next = S_MULR;
        end
      end
      S_MULR: begin
        cmd.sel_final  = 1'b1;
        cmd.fmul_start = 1'b1;
        state_next = S_WAITR;
      end
      S_WAITR: begin
        cmd.sel_final = 1'b1;
        if (status.fmul_done) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/ternary_packed_dot_product.sv
// Top level of the ternary packed dot product block.
// Usage:
//   An item is taken at a clock edge with start high and busy low. item.op
//   selects an activation load (one signed byte into the vector store and
//   the running activation sum) or a weight byte of four 2-bit codes.
//   An activation transaction leaves busy low.
//   A weight transaction does a store read, then four MACs.
//   The last weight byte of a row adds the end-of-row pass: int to fp32
//   normalization, one shift per cycle; then two passes through the shared
//   iterative fp32 multiplier (scale product, then dot times scale).
//   The result shows on result for one cycle with done high, in the cycle
//   in which busy drops; it cannot be held off.
//   Config writes (wr_en, wr_index, wr_data) take effect at once and
//   are to be made while the block is idle; the block does not enforce it.
//   Reset (rst, synchronous) restores the register defaults and clears
//   positions, sums and the row counter; the store itself is not cleared.
module ternary_packed_dot_product
  import tpd_pkg::*;
#(
  parameter int MAX_VECTOR = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        done,
  output result_t     result
);

  cmd_t    cmd;
  status_t status;

  tpd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (item.op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tpd_datapath #(.MAX_VECTOR(MAX_VECTOR)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .result   (result)
  );

endmodule

### src/tpd_checker.sv
// Port-level assertions for the ternary packed dot product block, with bind.
module tpd_checker
  import tpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input item_t       item,
  input logic        wr_en,
  input logic [1:0]  wr_index,
  input logic [31:0] wr_data,
  input logic        done,
  input result_t     result
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$isunknown(result))
    else $error("result while busy or unknown");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result right after a transaction was taken");

  a_weight_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_WEIGHT) |=> busy)
    else $error("weight transaction did not raise busy");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !busy && !$isunknown({wr_index, wr_data}))
    else $error("config write while busy or unknown");

endmodule

bind ternary_packed_dot_product tpd_checker u_tpd_checker (.*);
